@@ hdl/bced_pkg.sv @@
package bced_pkg;

    localparam int DEF_TICK_WIDTH = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TICKS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS     = 2'd3;

    localparam logic        ACTIVE_LEVEL_RST   = 1'b0;
    localparam logic [2:0]  DEBOUNCE_TICKS_RST = 3'd3;
    localparam logic [15:0] SHORT_TICKS_RST    = 16'd60;
    localparam logic [15:0] LONG_TICKS_RST     = 16'd200;

    localparam logic [2:0] EV_DOWN   = 3'd0;
    localparam logic [2:0] EV_UP     = 3'd1;
    localparam logic [2:0] EV_REPEAT = 3'd2;
    localparam logic [2:0] EV_SINGLE = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;
    localparam logic [2:0] EV_LSTART = 3'd5;
    localparam logic [2:0] EV_HOLD   = 3'd6;
    localparam logic [2:0] EV_NONE   = 3'd7;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PRESSED  = 3'd1;
    localparam logic [2:0] PH_RELEASED = 3'd2;
    localparam logic [2:0] PH_REPRESS  = 3'd3;
    localparam logic [2:0] PH_LONG     = 3'd5;

    localparam logic [3:0] REPEAT_MAX = 4'd15;

    typedef struct packed {
        logic key_down;
        logic key_up;
        logic key_again;
        logic click_one;
        logic click_two;
        logic long_start;
        logic long_hold;
    } evt_flags_t;

endpackage

@@ hdl/bced_debounce.sv @@
module bced_debounce (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       sample,
    input  logic [2:0] settle_len,
    output logic       level_next
);

    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       level_reg;
    logic [3:0] run_len;

    assign run_len = {1'b0, count_reg} + 4'd1;

    always_comb begin
        level_next = level_reg;
        count_next = 3'd0;
        if (sample != level_reg) begin
            if (run_len >= {1'b0, settle_len}) begin
                level_next = sample;
            end else begin
                count_next = run_len[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            level_reg <= ~bced_pkg::ACTIVE_LEVEL_RST;
        end else if (en) begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

@@ hdl/bced_click_fsm.sv @@
module bced_click_fsm #(
    parameter int TickWidth = bced_pkg::DEF_TICK_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 pressed,
    input  logic [15:0]          gap_limit,
    input  logic [15:0]          hold_limit,
    output bced_pkg::evt_flags_t flags,
    output logic [2:0]           event_next,
    output logic [3:0]           repeat_next
);

    localparam int CmpW = (TickWidth > 16) ? TickWidth : 16;

    logic [2:0]           phase_reg;
    logic [2:0]           phase_next;
    logic [TickWidth-1:0] tick_reg;
    logic [TickWidth-1:0] tick_next;
    logic [TickWidth-1:0] tick_inc;
    logic [3:0]           repeat_reg;
    logic [2:0]           event_reg;
    logic [CmpW-1:0]      tick_ext;
    logic [CmpW-1:0]      short_ext;
    logic [CmpW-1:0]      long_ext;

    assign tick_inc  = (phase_reg != bced_pkg::PH_IDLE && tick_reg != {TickWidth{1'b1}})
                       ? tick_reg + 1'b1 : tick_reg;
    assign tick_ext  = CmpW'(tick_inc);
    assign short_ext = CmpW'(gap_limit);
    assign long_ext  = CmpW'(hold_limit);

    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_inc;
        repeat_next = repeat_reg;
        event_next  = event_reg;
        flags       = '0;
        case (phase_reg)
            bced_pkg::PH_IDLE: begin
                if (pressed) begin
                    event_next     = bced_pkg::EV_DOWN;
                    flags.key_down = 1'b1;
                    tick_next      = '0;
                    repeat_next    = 4'd1;
                    phase_next     = bced_pkg::PH_PRESSED;
                end else begin
                    event_next = bced_pkg::EV_NONE;
                end
            end
            bced_pkg::PH_PRESSED: begin
                if (!pressed) begin
                    event_next   = bced_pkg::EV_UP;
                    flags.key_up = 1'b1;
                    tick_next    = '0;
                    phase_next   = bced_pkg::PH_RELEASED;
                end else if (tick_ext > long_ext) begin
                    event_next       = bced_pkg::EV_LSTART;
                    flags.long_start = 1'b1;
                    phase_next       = bced_pkg::PH_LONG;
                end
            end
            bced_pkg::PH_RELEASED: begin
                if (pressed) begin
                    event_next     = bced_pkg::EV_DOWN;
                    flags.key_down = 1'b1;
                    if (repeat_reg < bced_pkg::REPEAT_MAX) begin
                        repeat_next = repeat_reg + 4'd1;
                    end
                    flags.click_two = (repeat_next == 4'd2);
                    flags.key_again = 1'b1;
                    tick_next       = '0;
                    phase_next      = bced_pkg::PH_REPRESS;
                end else if (tick_ext > short_ext) begin
                    if (repeat_reg == 4'd1) begin
                        event_next      = bced_pkg::EV_SINGLE;
                        flags.click_one = 1'b1;
                    end else if (repeat_reg == 4'd2) begin
                        event_next = bced_pkg::EV_DOUBLE;
                    end
                    phase_next = bced_pkg::PH_IDLE;
                end
            end
            bced_pkg::PH_REPRESS: begin
                if (!pressed) begin
                    event_next   = bced_pkg::EV_UP;
                    flags.key_up = 1'b1;
                    if (tick_ext < short_ext) begin
                        tick_next  = '0;
                        phase_next = bced_pkg::PH_RELEASED;
                    end else begin
                        phase_next = bced_pkg::PH_IDLE;
                    end
                end
            end
            bced_pkg::PH_LONG: begin
                if (pressed) begin
                    event_next      = bced_pkg::EV_HOLD;
                    flags.long_hold = 1'b1;
                end else begin
                    event_next   = bced_pkg::EV_UP;
                    flags.key_up = 1'b1;
                    phase_next   = bced_pkg::PH_IDLE;
                end
            end
            default: begin
                tick_next = tick_inc;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= bced_pkg::PH_IDLE;
            tick_reg   <= '0;
            repeat_reg <= 4'd0;
            event_reg  <= bced_pkg::EV_NONE;
        end else if (en) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            repeat_reg <= repeat_next;
            event_reg  <= event_next;
        end
    end

endmodule

@@ hdl/button_click_event_detector_unit.sv @@
// Button debounce and click event detector.
// Input channel (s_valid/s_ready, s_pin_sample): one raw pin sample per
// transaction, one transaction per tick of the sampling clock.
// Result channel (m_valid/m_ready): exactly one result transaction per input
// transaction, carrying the seven event flags fired on that tick, the last
// stored event code, the press count of the current click sequence and the
// debounced level.
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle while the receiver takes results; the state update and the result
// register both load on the accepting edge.
// Stalls: s_ready stays high while the result register is empty or being
// emptied in the same cycle; when the receiver holds m_ready low the result
// is kept and s_ready drops until it is taken.
// Reset (aresetn low, synchronous): registers return to active low level,
// 3 debounce ticks, 60 short ticks, 200 long ticks; the machine goes idle,
// counters clear, the debounced level is the released level, no result held.
// Configuration (cfg_we, cfg_index, cfg_wdata) takes effect on the next tick.
module button_click_event_detector_unit #(
    parameter int TickWidth = bced_pkg::DEF_TICK_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bced_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bced_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_pin_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_fired_press_down,
    output logic                            m_fired_press_up,
    output logic                            m_fired_press_repeat,
    output logic                            m_fired_single_click,
    output logic                            m_fired_double_click,
    output logic                            m_fired_long_start,
    output logic                            m_fired_long_hold,
    output logic [2:0]                      m_last_event,
    output logic [3:0]                      m_press_count,
    output logic                            m_filtered_level
);

    logic        active_level_reg;
    logic [2:0]  debounce_ticks_reg;
    logic [15:0] short_ticks_reg;
    logic [15:0] long_ticks_reg;

    logic        m_valid_reg;
    logic        accept;
    logic        level_next;
    logic        pressed;
    logic [2:0]  event_next;
    logic [3:0]  repeat_next;

    bced_pkg::evt_flags_t flags;
    bced_pkg::evt_flags_t flags_reg;
    logic [2:0]           event_reg;
    logic [3:0]           count_reg;
    logic                 level_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pressed = (level_next == active_level_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg   <= bced_pkg::ACTIVE_LEVEL_RST;
            debounce_ticks_reg <= bced_pkg::DEBOUNCE_TICKS_RST;
            short_ticks_reg    <= bced_pkg::SHORT_TICKS_RST;
            long_ticks_reg     <= bced_pkg::LONG_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bced_pkg::REG_ACTIVE_LEVEL:   active_level_reg   <= cfg_wdata[0];
                bced_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata[2:0];
                bced_pkg::REG_SHORT_TICKS:    short_ticks_reg    <= cfg_wdata;
                bced_pkg::REG_LONG_TICKS:     long_ticks_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bced_debounce u_debounce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (accept),
        .sample     (s_pin_sample),
        .settle_len (debounce_ticks_reg),
        .level_next (level_next)
    );

    bced_click_fsm #(
        .TickWidth (TickWidth)
    ) u_click_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (accept),
        .pressed     (pressed),
        .gap_limit   (short_ticks_reg),
        .hold_limit  (long_ticks_reg),
        .flags       (flags),
        .event_next  (event_next),
        .repeat_next (repeat_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            flags_reg <= flags;
            event_reg <= event_next;
            count_reg <= repeat_next;
            level_reg <= level_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_fired_press_down   = flags_reg.key_down;
    assign m_fired_press_up     = flags_reg.key_up;
    assign m_fired_press_repeat = flags_reg.key_again;
    assign m_fired_single_click = flags_reg.click_one;
    assign m_fired_double_click = flags_reg.click_two;
    assign m_fired_long_start   = flags_reg.long_start;
    assign m_fired_long_hold    = flags_reg.long_hold;
    assign m_last_event         = event_reg;
    assign m_press_count        = count_reg;
    assign m_filtered_level     = level_reg;

endmodule

@@ dv/button_click_event_detector_unit_tb.sv @@
`timescale 1ns / 100ps

module button_click_event_detector_unit_tb;

    localparam int TW             = bced_pkg::DEF_TICK_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 177;

    typedef struct packed {
        bced_pkg::evt_flags_t flags;
        logic [2:0]           last_event;
        logic [3:0]           press_count;
        logic                 level;
    } tick_result_t;

    logic                             aclk         = 1'b0;
    logic                             aresetn      = 1'b0;
    logic                             cfg_we       = 1'b0;
    logic [bced_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [bced_pkg::CFG_DATA_W-1:0]  cfg_wdata    = '0;
    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic                             s_pin_sample = 1'b0;
    logic                             m_valid;
    logic                             m_ready      = 1'b0;
    logic                             m_fired_press_down;
    logic                             m_fired_press_up;
    logic                             m_fired_press_repeat;
    logic                             m_fired_single_click;
    logic                             m_fired_double_click;
    logic                             m_fired_long_start;
    logic                             m_fired_long_hold;
    logic [2:0]                       m_last_event;
    logic [3:0]                       m_press_count;
    logic                             m_filtered_level;

    button_click_event_detector_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_pin_sample         (s_pin_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_fired_press_down   (m_fired_press_down),
        .m_fired_press_up     (m_fired_press_up),
        .m_fired_press_repeat (m_fired_press_repeat),
        .m_fired_single_click (m_fired_single_click),
        .m_fired_double_click (m_fired_double_click),
        .m_fired_long_start   (m_fired_long_start),
        .m_fired_long_hold    (m_fired_long_hold),
        .m_last_event         (m_last_event),
        .m_press_count        (m_press_count),
        .m_filtered_level     (m_filtered_level)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // configuration, debounce and click machine mirror
    logic          cfg_active;
    logic [2:0]    cfg_debounce;
    logic [15:0]   cfg_short;
    logic [15:0]   cfg_long;
    logic [2:0]    click_phase;
    logic [TW-1:0] tick_cnt;
    logic [3:0]    press_cnt;
    logic [2:0]    glitch_cnt;
    logic          stable_lvl;
    logic [2:0]    stored_ev;

    tick_result_t exp_q[$];
    int idle_pct       = 0;
    int stall_pct      = 0;
    int field_errors   = 0;
    int results_seen   = 0;
    int samples_sent   = 0;
    int settings_used  = 0;
    int n_single       = 0;
    int n_double       = 0;
    int n_long         = 0;
    int peak_presses   = 0;
    int quiet_cycles   = 0;

    function automatic void reset_model();
        cfg_active   = bced_pkg::ACTIVE_LEVEL_RST;
        cfg_debounce = bced_pkg::DEBOUNCE_TICKS_RST;
        cfg_short    = bced_pkg::SHORT_TICKS_RST;
        cfg_long     = bced_pkg::LONG_TICKS_RST;
        click_phase  = bced_pkg::PH_IDLE;
        tick_cnt     = '0;
        press_cnt    = '0;
        glitch_cnt   = '0;
        stable_lvl   = ~bced_pkg::ACTIVE_LEVEL_RST;
        stored_ev    = bced_pkg::EV_NONE;
    endfunction

    function automatic tick_result_t advance_tick(input logic pin);
        tick_result_t r;
        int           run;
        logic         pressed;
        r = '0;
        if (click_phase != bced_pkg::PH_IDLE && tick_cnt != '1)
            tick_cnt++;
        if (pin != stable_lvl) begin
            run = glitch_cnt + 1;
            if (run >= cfg_debounce) begin
                stable_lvl = pin;
                glitch_cnt = '0;
            end else begin
                glitch_cnt = run[2:0];
            end
        end else begin
            glitch_cnt = '0;
        end
        pressed = (stable_lvl == cfg_active);
        case (click_phase)
            bced_pkg::PH_IDLE: begin
                if (pressed) begin
                    stored_ev        = bced_pkg::EV_DOWN;
                    r.flags.key_down = 1'b1;
                    tick_cnt         = '0;
                    press_cnt        = 4'd1;
                    click_phase      = bced_pkg::PH_PRESSED;
                end else begin
                    stored_ev = bced_pkg::EV_NONE;
                end
            end
            bced_pkg::PH_PRESSED: begin
                if (!pressed) begin
                    stored_ev      = bced_pkg::EV_UP;
                    r.flags.key_up = 1'b1;
                    tick_cnt       = '0;
                    click_phase    = bced_pkg::PH_RELEASED;
                end else if (tick_cnt > cfg_long) begin
                    stored_ev          = bced_pkg::EV_LSTART;
                    r.flags.long_start = 1'b1;
                    click_phase        = bced_pkg::PH_LONG;
                end
            end
            bced_pkg::PH_RELEASED: begin
                if (pressed) begin
                    stored_ev        = bced_pkg::EV_DOWN;
                    r.flags.key_down = 1'b1;
                    if (press_cnt != bced_pkg::REPEAT_MAX)
                        press_cnt++;
                    if (press_cnt == 4'd2)
                        r.flags.click_two = 1'b1;
                    r.flags.key_again = 1'b1;
                    tick_cnt          = '0;
                    click_phase       = bced_pkg::PH_REPRESS;
                end else if (tick_cnt > cfg_short) begin
                    if (press_cnt == 4'd1) begin
                        stored_ev         = bced_pkg::EV_SINGLE;
                        r.flags.click_one = 1'b1;
                    end else if (press_cnt == 4'd2) begin
                        stored_ev = bced_pkg::EV_DOUBLE;
                    end
                    click_phase = bced_pkg::PH_IDLE;
                end
            end
            bced_pkg::PH_REPRESS: begin
                if (!pressed) begin
                    stored_ev      = bced_pkg::EV_UP;
                    r.flags.key_up = 1'b1;
                    if (tick_cnt < cfg_short) begin
                        tick_cnt    = '0;
                        click_phase = bced_pkg::PH_RELEASED;
                    end else begin
                        click_phase = bced_pkg::PH_IDLE;
                    end
                end
            end
            bced_pkg::PH_LONG: begin
                if (pressed) begin
                    stored_ev         = bced_pkg::EV_HOLD;
                    r.flags.long_hold = 1'b1;
                end else begin
                    stored_ev      = bced_pkg::EV_UP;
                    r.flags.key_up = 1'b1;
                    click_phase    = bced_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase
        r.last_event  = stored_ev;
        r.press_count = press_cnt;
        r.level       = stable_lvl;
        n_single += r.flags.click_one;
        n_double += r.flags.click_two;
        n_long   += r.flags.long_start;
        if (press_cnt > peak_presses)
            peak_presses = press_cnt;
        return r;
    endfunction

    task automatic send_sample(input logic pin);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pin_sample <= pin;
        do @(posedge aclk); while (!s_ready);
        exp_q.push_back(advance_tick(pin));
        samples_sent++;
    endtask

    task automatic settle_outputs();
        s_valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bced_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bced_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            bced_pkg::REG_ACTIVE_LEVEL:   cfg_active   = data[0];
            bced_pkg::REG_DEBOUNCE_TICKS: cfg_debounce = data[2:0];
            bced_pkg::REG_SHORT_TICKS:    cfg_short    = data;
            bced_pkg::REG_LONG_TICKS:     cfg_long     = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] act, input logic [15:0] dbc,
                              input logic [15:0] short_t, input logic [15:0] long_t);
        settle_outputs();
        write_reg(bced_pkg::REG_ACTIVE_LEVEL, act);
        write_reg(bced_pkg::REG_DEBOUNCE_TICKS, dbc);
        write_reg(bced_pkg::REG_SHORT_TICKS, short_t);
        write_reg(bced_pkg::REG_LONG_TICKS, long_t);
        settings_used++;
    endtask

    task automatic send_pattern(input logic [63:0] pins, input int count);
        for (int i = count - 1; i >= 0; i--)
            send_sample(pins[i]);
    endtask

    task automatic test_click_patterns();
        set_config(16'd0, 16'd1, 16'd2, 16'd5);
        send_pattern(64'b1011111, 7);
        send_pattern(64'b0101111, 7);
        send_pattern(64'b010101111, 9);
        send_pattern(64'b0100011, 7);
    endtask

    task automatic test_long_press();
        send_pattern(64'b0000000011, 10);
    endtask

    task automatic test_debounce_filter();
        settle_outputs();
        write_reg(bced_pkg::REG_DEBOUNCE_TICKS, 16'd3);
        send_pattern(64'b0010001101111, 13);
        send_pattern(64'b1111, 4);
    endtask

    task automatic test_active_level_swap();
        settle_outputs();
        write_reg(bced_pkg::REG_DEBOUNCE_TICKS, 16'd0);
        send_pattern(64'b00, 2);
        settle_outputs();
        write_reg(bced_pkg::REG_ACTIVE_LEVEL, 16'd1);
        send_pattern(64'b0100000, 7);
    endtask

    task automatic test_random_clicks(input int n_items);
        int   sent;
        int   seg_len;
        int   pick;
        int   taps;
        int   hold;
        logic pin;
        sent = 0;
        pin  = ~cfg_active;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                seg_len = $urandom_range(1, 6);
                if (seg_len > n_items - sent)
                    seg_len = n_items - sent;
                repeat (seg_len) send_sample(1'($urandom_range(1)));
            end else if (pick == 1) begin
                seg_len = 0;
                taps    = $urandom_range(2, 18);
                repeat (taps) begin
                    if (seg_len < n_items - sent) begin
                        hold = ((cfg_debounce == 0) ? 1 : cfg_debounce) + $urandom_range(0, 1);
                        repeat (hold) send_sample(cfg_active);
                        repeat (hold) send_sample(~cfg_active);
                        seg_len += 2 * hold;
                    end
                end
                pin = ~cfg_active;
            end else begin
                pin = ~pin;
                if (pick <= 3)
                    seg_len = $urandom_range(1, 3);
                else if (pick <= 6)
                    seg_len = cfg_debounce + $urandom_range(0, cfg_short + 2);
                else
                    seg_len = cfg_debounce + cfg_long + $urandom_range(0, 4);
                if (seg_len > 300)
                    seg_len = 300;
                if (seg_len < 1)
                    seg_len = 1;
                if (seg_len > n_items - sent)
                    seg_len = n_items - sent;
                repeat (seg_len) send_sample(pin);
            end
            sent += seg_len;
        end
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            field_errors++;
            if (field_errors <= 10)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_q.size() == 0) begin
                field_errors++;
                if (field_errors <= 10)
                    $display("%0t: result transaction with no sample pending", $time);
            end else begin
                want = exp_q.pop_front();
                compare_field("m_fired_press_down", want.flags.key_down, m_fired_press_down);
                compare_field("m_fired_press_up", want.flags.key_up, m_fired_press_up);
                compare_field("m_fired_press_repeat", want.flags.key_again,
                              m_fired_press_repeat);
                compare_field("m_fired_single_click", want.flags.click_one,
                              m_fired_single_click);
                compare_field("m_fired_double_click", want.flags.click_two,
                              m_fired_double_click);
                compare_field("m_fired_long_start", want.flags.long_start, m_fired_long_start);
                compare_field("m_fired_long_hold", want.flags.long_hold, m_fired_long_hold);
                compare_field("last_event", want.last_event, m_last_event);
                compare_field("press_count", want.press_count, m_press_count);
                compare_field("filtered_level", want.level, m_filtered_level);
                results_seen++;
            end
        end
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("button_click_event_detector_unit: mismatch");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_click_patterns();
        test_long_press();
        test_debounce_filter();
        test_active_level_swap();

        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        test_random_clicks(RANDOM_ITEMS);

        set_config(16'd1, 16'd7, 16'd20, 16'd40);
        idle_pct = 53;
        test_random_clicks(RANDOM_ITEMS);

        set_config(16'd0, 16'd1, 16'd6, 16'd12);
        idle_pct  = 0;
        stall_pct = 53;
        test_random_clicks(RANDOM_ITEMS);

        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 24)), 16'($urandom_range(0, 48)));
        idle_pct  = 16;
        stall_pct = 16;
        test_random_clicks(RANDOM_ITEMS);

        set_config(16'(bced_pkg::ACTIVE_LEVEL_RST), 16'(bced_pkg::DEBOUNCE_TICKS_RST),
                   bced_pkg::SHORT_TICKS_RST, bced_pkg::LONG_TICKS_RST);
        test_random_clicks(RANDOM_ITEMS);

        settle_outputs();
        $display("Checked %0d results from %0d pin samples across %0d register settings.",
                 results_seen, samples_sent, settings_used);
        $display("Saw %0d single clicks, %0d double clicks, %0d long presses, peak count %0d.",
                 n_single, n_double, n_long, peak_presses);
        if (field_errors == 0 && exp_q.size() == 0) begin
            $display("button_click_event_detector_unit: match");
        end else begin
            $display("button_click_event_detector_unit: mismatch");
        end
        $finish;
    end

endmodule
